FILE: sv/mm_pkg.sv
// Shared constants, command type and helpers for the matrix multiply block.
`default_nettype none
package mm_pkg;

   localparam int MAX_DIM     = 8;
   localparam int ELEM_BITS   = 16;
   localparam int DIM_BITS    = 4;                       // config register width
   localparam int IDX_BITS    = $clog2(MAX_DIM);         // row / column / inner index
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1); // load counters reach the depth
   localparam int MUL_BITS    = 2 * ELEM_BITS;
   localparam int PV_BITS     = 35;
   localparam int CMD_DEPTH   = 4;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   localparam logic [1:0] REG_ROWS_LEFT  = 2'd0;
   localparam logic [1:0] REG_INNER_DIM  = 2'd1;
   localparam logic [1:0] REG_COLS_RIGHT = 2'd2;

   localparam logic FUNC_LEFT  = 1'b0;
   localparam logic FUNC_RIGHT = 1'b1;

   // One store write, optionally closing the load and launching a run.
   typedef struct packed {
      logic                 is_right;
      logic                 run;
      logic [ADDR_BITS-1:0] addr;
      logic [ELEM_BITS-1:0] data;
      logic [DIM_BITS-1:0]  dim_m;
      logic [DIM_BITS-1:0]  dim_k;
      logic [DIM_BITS-1:0]  dim_n;
   } cmd_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
      logic [DIM_BITS-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_BITS'(1);
      end else if (d > DIM_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/mm_front.sv
// Front end: load counters, surplus filtering and store write commands.
`default_nettype none
module mm_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              accept,
   input  wire                              func,
   input  wire  [mm_pkg::ELEM_BITS-1:0]     value,
   input  wire  [mm_pkg::DIM_BITS-1:0]      dim_m,
   input  wire  [mm_pkg::DIM_BITS-1:0]      dim_k,
   input  wire  [mm_pkg::DIM_BITS-1:0]      dim_n,
   output logic                             push,
   output mm_pkg::cmd_type                  cmd
);
   import mm_pkg::*;

   logic [CNT_BITS-1:0] left_count_ff, left_count_in;
   logic [CNT_BITS-1:0] right_count_ff, right_count_in;
   logic [CNT_BITS-1:0] left_size, right_size;
   logic [CNT_BITS-1:0] right_next;

   assign left_size  = CNT_BITS'(dim_m) * CNT_BITS'(dim_k);
   assign right_size = CNT_BITS'(dim_k) * CNT_BITS'(dim_n);
   assign right_next = right_count_ff + CNT_BITS'(1);

   always_comb begin
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      push           = 1'b0;
      cmd.is_right   = func;
      cmd.run        = 1'b0;
      cmd.addr       = (func == FUNC_RIGHT) ? right_count_ff[ADDR_BITS-1:0]
                                            : left_count_ff[ADDR_BITS-1:0];
      cmd.data       = value;
      cmd.dim_m      = dim_m;
      cmd.dim_k      = dim_k;
      cmd.dim_n      = dim_n;
      if (accept) begin
         if (func == FUNC_LEFT) begin
            if (left_count_ff < left_size) begin
               push          = 1'b1;
               left_count_in = left_count_ff + CNT_BITS'(1);
            end
         end else if (right_count_ff < right_size) begin
            push           = 1'b1;
            right_count_in = right_next;
            // last right element: launch the run and start a fresh load
            if (right_next == right_size) begin
               cmd.run        = 1'b1;
               left_count_in  = '0;
               right_count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else begin
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/mm_cmd_fifo.sv
// Short command queue between the front end and the compute back end.
`default_nettype none
module mm_cmd_fifo (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  mm_pkg::cmd_type  push_cmd,
   input  wire              pop,
   output mm_pkg::cmd_type  head,
   output logic             not_empty,
   output logic             full
);
   import mm_pkg::*;

   localparam int PTR_BITS = $clog2(CMD_DEPTH);
   localparam int LVL_BITS = $clog2(CMD_DEPTH + 1);

   cmd_type               slot_ff [CMD_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [LVL_BITS-1:0]   level_ff, level_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (level_ff != '0);
   assign full      = (level_ff == LVL_BITS'(CMD_DEPTH));

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + LVL_BITS'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LVL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/mm_back.sv
// Back end: element stores, product sequencer and multiply-accumulate pipeline.
`default_nettype none
module mm_back (
   input  wire                              clock,
   input  wire                              reset,
   input  mm_pkg::cmd_type                  head,
   input  wire                              not_empty,
   output logic                             pop,
   output logic                             rsp_strobe,
   output logic signed [mm_pkg::PV_BITS-1:0] rsp_product_value,
   output logic [mm_pkg::IDX_BITS-1:0]      rsp_result_row,
   output logic [mm_pkg::IDX_BITS-1:0]      rsp_result_col,
   output logic                             rsp_last_of_run
);
   import mm_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   typedef struct packed {
      logic                first;
      logic                last;
      logic                end_run;
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
   } tag_type;

   logic [ELEM_BITS-1:0] left_mem  [STORE_DEPTH];
   logic [ELEM_BITS-1:0] right_mem [STORE_DEPTH];

   logic [0:0]           state_ff, state_in;
   logic [DIM_BITS-1:0]  m_ff, m_in, k_ff, k_in, n_ff, n_in;
   logic [IDX_BITS-1:0]  i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [ADDR_BITS-1:0] row_base_ff, row_base_in;
   logic [ADDR_BITS-1:0] rb_ff, rb_in;
   logic [ADDR_BITS-1:0] la;
   logic                 issue, t_last, j_last, i_last;
   tag_type              tag0;

   logic                 v1_ff, v2_ff;
   tag_type              tag1_ff, tag2_ff;
   logic signed [ELEM_BITS-1:0] left_rd_ff, right_rd_ff;
   logic signed [MUL_BITS-1:0]  prod_ff;
   logic signed [PV_BITS-1:0]   acc_ff, sum;

   assign issue  = (state_ff == ST_RUN);
   assign pop    = (state_ff == ST_IDLE) && not_empty;
   assign t_last = ({1'b0, t_ff} == k_ff - DIM_BITS'(1));
   assign j_last = ({1'b0, j_ff} == n_ff - DIM_BITS'(1));
   assign i_last = ({1'b0, i_ff} == m_ff - DIM_BITS'(1));
   assign la     = row_base_ff + ADDR_BITS'(t_ff);

   always_comb begin
      tag0.first   = (t_ff == '0);
      tag0.last    = t_last;
      tag0.end_run = i_last && j_last;
      tag0.row     = i_ff;
      tag0.col     = j_ff;
   end

   // run sequencer: inner index fastest, then column, then row
   always_comb begin
      state_in    = state_ff;
      m_in        = m_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      t_in        = t_ff;
      row_base_in = row_base_ff;
      rb_in       = rb_ff;
      if (state_ff == ST_IDLE) begin
         if (pop && head.run) begin
            state_in    = ST_RUN;
            m_in        = head.dim_m;
            k_in        = head.dim_k;
            n_in        = head.dim_n;
            i_in        = '0;
            j_in        = '0;
            t_in        = '0;
            row_base_in = '0;
            rb_in       = '0;
         end
      end else begin
         if (t_last) begin
            t_in = '0;
            if (j_last) begin
               j_in        = '0;
               rb_in       = '0;
               row_base_in = row_base_ff + ADDR_BITS'(k_ff);
               i_in        = i_ff + IDX_BITS'(1);
               if (i_last) begin
                  state_in = ST_IDLE;
               end
            end else begin
               j_in  = j_ff + IDX_BITS'(1);
               rb_in = ADDR_BITS'(j_in);
            end
         end else begin
            t_in  = t_ff + IDX_BITS'(1);
            rb_in = rb_ff + ADDR_BITS'(n_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !head.is_right) begin
         left_mem[head.addr] <= head.data;
      end
      left_rd_ff <= left_mem[la];
   end

   always_ff @(posedge clock) begin
      if (pop && head.is_right) begin
         right_mem[head.addr] <= head.data;
      end
      right_rd_ff <= right_mem[rb_ff];
   end

   assign sum = (tag2_ff.first ? PV_BITS'(0) : acc_ff) + PV_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      t_ff        <= t_in;
      row_base_ff <= row_base_in;
      rb_ff       <= rb_in;
      tag1_ff     <= tag0;
      tag2_ff     <= tag1_ff;
      prod_ff     <= left_rd_ff * right_rd_ff;
      if (v2_ff) begin
         acc_ff <= sum;
      end
      if (v2_ff && tag2_ff.last) begin
         rsp_product_value <= sum;
         rsp_result_row    <= tag2_ff.row;
         rsp_result_col    <= tag2_ff.col;
         rsp_last_of_run   <= tag2_ff.end_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         v1_ff      <= issue;
         v2_ff      <= v1_ff;
         rsp_strobe <= v2_ff && tag2_ff.last;
      end
   end

endmodule
`default_nettype wire

FILE: sv/matrix_multiply.sv
// Top level of the fixed-point dense matrix multiply block.
//
//   channel   | ports                                   | transaction
//   ----------+-----------------------------------------+------------------------------
//   request   | start, busy, req_func, req_value        | start && !busy at clock edge
//   response  | rsp_strobe, rsp_product_value, rsp_*    | one cycle with rsp_strobe high
//   config    | psel penable pwrite paddr pwdata prdata | psel && penable && pwrite
//
// An element is accepted into the command queue and written to its store once it
// reaches the head while the back end is idle. The last right element launches a
// run on the single multiply-accumulate unit; each product passes the store read,
// product and result registers; each result is strobed with its row and column.
// busy rises only when the four-entry command queue fills, i.e. during a run.
// Synchronous reset clears counters, queue and sequencer; the receiver cannot stall.
`default_nettype none
module matrix_multiply (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire                                req_func,
   input  wire  signed [mm_pkg::ELEM_BITS-1:0] req_value,
   output logic                               rsp_strobe,
   output logic signed [mm_pkg::PV_BITS-1:0]   rsp_product_value,
   output logic [mm_pkg::IDX_BITS-1:0]        rsp_result_row,
   output logic [mm_pkg::IDX_BITS-1:0]        rsp_result_col,
   output logic                               rsp_last_of_run,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [mm_pkg::CSR_AW-1:0]          paddr,
   input  wire  [mm_pkg::CSR_DW-1:0]          pwdata,
   output logic [mm_pkg::CSR_DW-1:0]          prdata,
   output logic                               pready
);
   import mm_pkg::*;

   // raw register values, read back as written
   logic [DIM_BITS-1:0] rows_left_ff, inner_dim_ff, cols_right_ff;
   logic [1:0]          reg_index;
   logic                csr_write;
   logic                accept;
   logic                push, pop, not_empty, fifo_full;
   cmd_type             front_cmd, head;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   // hold off new elements only when the command queue has no room
   assign busy   = fifo_full;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_left_ff  <= DIM_BITS'(MAX_DIM);
         inner_dim_ff  <= DIM_BITS'(MAX_DIM);
         cols_right_ff <= DIM_BITS'(MAX_DIM);
      end else if (csr_write) begin
         case (reg_index)
            REG_ROWS_LEFT:  rows_left_ff  <= pwdata[DIM_BITS-1:0];
            REG_INNER_DIM:  inner_dim_ff  <= pwdata[DIM_BITS-1:0];
            REG_COLS_RIGHT: cols_right_ff <= pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ROWS_LEFT:  prdata = CSR_DW'(rows_left_ff);
         REG_INNER_DIM:  prdata = CSR_DW'(inner_dim_ff);
         REG_COLS_RIGHT: prdata = CSR_DW'(cols_right_ff);
         default:        prdata = '0;
      endcase
   end

   // front end: count, drop surplus elements, tag the closing right element
   mm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .func   (req_func),
      .value  (req_value),
      .dim_m  (clamp_dim(rows_left_ff)),
      .dim_k  (clamp_dim(inner_dim_ff)),
      .dim_n  (clamp_dim(cols_right_ff)),
      .push   (push),
      .cmd    (front_cmd)
   );

   // queue: store writes stay in order behind a run, so a run always sees
   // the stores as they stood when its last element arrived
   mm_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (fifo_full)
   );

   // back end: apply writes, then sweep the product one MAC per cycle
   mm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .not_empty         (not_empty),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_product_value (rsp_product_value),
      .rsp_result_row    (rsp_result_row),
      .rsp_result_col    (rsp_result_col),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
`default_nettype wire
